// File: rtl/core/ktc_pkg.sv
package ktc_pkg;

   // Operation codes carried on req_op.
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_REMOVE = 3'd1;
   localparam logic [2:0] OP_UPDATE = 3'd2;
   localparam logic [2:0] OP_LOOKUP = 3'd3;
   localparam logic [2:0] OP_LIST   = 3'd4;

   // Status codes carried on rsp_status.
   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_DUP      = 3'd2;
   localparam logic [2:0] STAT_NOTFOUND = 3'd3;
   localparam logic [2:0] STAT_EMPTY    = 3'd4;

   // One table entry as held in the store.
   typedef struct packed {
      logic signed [31:0] key;
      logic [31:0]        value;
   } entry_type;

   // Write request from the sequencer to the store.
   typedef struct packed {
      logic      en;
      entry_type data;
   } mem_wr_type;

endpackage

// File: rtl/core/ktc_table.sv
module ktc_table import ktc_pkg::*; #(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  mem_wr_type        wr_req,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [ADDR_W-1:0] rd_addr,
   output entry_type         rd_data
);

   // Entry store: one write port and one registered read port.
   entry_type table_mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         table_mem[wr_addr] <= wr_req.data;
      end
      rd_data_ff <= table_mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/keyed_table_with_compaction.sv
// Response: an op on an empty table, a full insert or an insert into an empty table gives its
// word in the cycle after acceptance; search ops walk the occupied entries through the
// read port, remove then copies each later entry down, and list gives one word per cycle.
// Flow: one item at a time, each walking the single read port of the store; the receiver
// cannot stall, each word shows for one cycle.
// Reset: synchronous, active high; clears the entry count, the sequencer and the response strobe, not the store.
module keyed_table_with_compaction import ktc_pkg::*; #(
   parameter int CAPACITY = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_op,
   input  logic signed [31:0] req_key,
   input  logic [31:0]        req_value,
   output logic               rsp_strobe,
   output logic [2:0]         rsp_status,
   output logic signed [31:0] rsp_found_key,
   output logic [31:0]        rsp_found_value,
   output logic [3:0]         rsp_position,
   output logic               rsp_last
);

   // Count width holds CAPACITY itself; the index width addresses the store.
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

   // Sequencer states.
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEARCH = 2'd1;
   localparam logic [1:0] ST_SHIFT  = 2'd2;
   localparam logic [1:0] ST_LIST   = 2'd3;

   logic [1:0]         state_ff, state_in;
   logic [2:0]         op_ff, op_in;
   logic signed [31:0] key_ff, key_in;
   logic [31:0]        value_ff, value_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [CNT_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [CNT_W-1:0]   pos_ff, pos_in;

   logic               strobe_ff, strobe_in;
   logic [2:0]         status_ff, status_in;
   logic signed [31:0] fkey_ff, fkey_in;
   logic [31:0]        fvalue_ff, fvalue_in;
   logic [3:0]         position_ff, position_in;
   logic               last_ff, last_in;

   mem_wr_type         wr_req;
   logic [CNT_W-1:0]   wr_idx;
   logic [IDX_W-1:0]   wr_addr;
   logic [IDX_W-1:0]   rd_addr;
   entry_type          rd_data;

   logic               hit;
   logic               pend_is_last;
   logic [CNT_W-1:0]   pend_dst;

   // The store is read at the issue pointer every cycle; the data of the entry
   // issued in one cycle is compared, copied or reported in the next.
   ktc_table #(
      .DEPTH  (CAPACITY),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_req  (wr_req),
      .wr_addr (wr_addr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_addr      = iss_ff[IDX_W-1:0];
   assign wr_addr      = wr_idx[IDX_W-1:0];
   assign hit          = pend_vld_ff && (rd_data.key == key_ff);
   assign pend_is_last = (pend_idx_ff == cnt_ff - CNT_W'(1));
   assign pend_dst     = pend_idx_ff - CNT_W'(1);

   always_comb begin
      state_in    = state_ff;
      op_in       = op_ff;
      key_in      = key_ff;
      value_in    = value_ff;
      cnt_in      = cnt_ff;
      iss_in      = iss_ff;
      pend_vld_in = 1'b0;
      pend_idx_in = pend_idx_ff;
      pos_in      = pos_ff;

      strobe_in   = 1'b0;
      status_in   = STAT_OK;
      fkey_in     = '0;
      fvalue_in   = '0;
      position_in = '0;
      last_in     = 1'b1;

      wr_req      = '0;
      wr_idx      = '0;

      // The walking states share one issue pointer that steps through the
      // occupied entries, one read per cycle.
      if (state_ff != ST_IDLE) begin
         if (iss_ff < cnt_ff) begin
            iss_in      = iss_ff + CNT_W'(1);
            pend_vld_in = 1'b1;
            pend_idx_in = iss_ff;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_op;
               key_in   = req_key;
               value_in = req_value;
               iss_in   = '0;
               case (req_op)
                  OP_INSERT: begin
                     if (cnt_ff >= CNT_W'(CAPACITY)) begin
                        strobe_in = 1'b1;
                        status_in = STAT_FULL;
                     end else if (cnt_ff == '0) begin
                        // Nothing to search: the entry goes straight to the head.
                        wr_req.en         = 1'b1;
                        wr_req.data.key   = req_key;
                        wr_req.data.value = req_value;
                        cnt_in            = cnt_ff + CNT_W'(1);
                        strobe_in         = 1'b1;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_REMOVE, OP_UPDATE: begin
                     if (cnt_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_LOOKUP: begin
                     if (cnt_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = STAT_NOTFOUND;
                     end else begin
                        state_in = ST_SEARCH;
                     end
                  end
                  OP_LIST: begin
                     if (cnt_ff == '0) begin
                        strobe_in = 1'b1;
                        status_in = STAT_EMPTY;
                     end else begin
                        state_in = ST_LIST;
                     end
                  end
                  default: begin
                     // Undefined operations are dropped without a result.
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            if (hit) begin
               pend_vld_in = 1'b0;
               case (op_ff)
                  OP_INSERT: begin
                     strobe_in = 1'b1;
                     status_in = STAT_DUP;
                     state_in  = ST_IDLE;
                  end
                  OP_UPDATE: begin
                     wr_req.en         = 1'b1;
                     wr_req.data.key   = key_ff;
                     wr_req.data.value = value_ff;
                     wr_idx            = pend_idx_ff;
                     strobe_in         = 1'b1;
                     position_in       = 4'(pend_idx_ff);
                     state_in          = ST_IDLE;
                  end
                  OP_LOOKUP: begin
                     strobe_in   = 1'b1;
                     fkey_in     = rd_data.key;
                     fvalue_in   = rd_data.value;
                     position_in = 4'(pend_idx_ff);
                     state_in    = ST_IDLE;
                  end
                  default: begin
                     // Remove: close the gap by copying each later entry down.
                     pos_in   = pend_idx_ff;
                     iss_in   = pend_idx_ff + CNT_W'(1);
                     state_in = ST_SHIFT;
                  end
               endcase
            end else if (pend_vld_ff && pend_is_last) begin
               // The last occupied entry did not match.
               pend_vld_in = 1'b0;
               strobe_in   = 1'b1;
               state_in    = ST_IDLE;
               if (op_ff == OP_INSERT) begin
                  wr_req.en         = 1'b1;
                  wr_req.data.key   = key_ff;
                  wr_req.data.value = value_ff;
                  wr_idx            = cnt_ff;
                  position_in       = 4'(cnt_ff);
                  cnt_in            = cnt_ff + CNT_W'(1);
               end else begin
                  status_in = STAT_NOTFOUND;
               end
            end
         end

         ST_SHIFT: begin
            if (pend_vld_ff) begin
               wr_req.en   = 1'b1;
               wr_req.data = rd_data;
               wr_idx      = pend_dst;
            end else if (iss_ff >= cnt_ff) begin
               cnt_in      = cnt_ff - CNT_W'(1);
               strobe_in   = 1'b1;
               position_in = 4'(pos_ff);
               state_in    = ST_IDLE;
            end
         end

         ST_LIST: begin
            if (pend_vld_ff) begin
               strobe_in   = 1'b1;
               fkey_in     = rd_data.key;
               fvalue_in   = rd_data.value;
               position_in = 4'(pend_idx_ff);
               last_in     = pend_is_last;
               if (pend_is_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         cnt_ff      <= '0;
         iss_ff      <= '0;
         pend_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         iss_ff      <= iss_in;
         pend_vld_ff <= pend_vld_in;
         strobe_ff   <= strobe_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      value_ff    <= value_in;
      pend_idx_ff <= pend_idx_in;
      pos_ff      <= pos_in;
      status_ff   <= status_in;
      fkey_ff     <= fkey_in;
      fvalue_ff   <= fvalue_in;
      position_ff <= position_in;
      last_ff     <= last_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_status      = status_ff;
   assign rsp_found_key   = fkey_ff;
   assign rsp_found_value = fvalue_ff;
   assign rsp_position    = position_ff;
   assign rsp_last        = last_ff;

endmodule
